[rtl/qxmm_pkg.sv]
// Package with the types, widths and constants of the quad X motor mixer.
package qxmm_pkg;

	localparam int NUM_MOTORS  = 4;
	localparam int FIELD_W     = 24;
	localparam int DUTY_W      = 16;
	localparam int SUM_W       = 57;
	localparam int SHIFT_W     = 28;
	localparam int OMEGA_W     = 24;
	localparam int K_W         = 26;
	localparam int X_W         = OMEGA_W + K_W;
	localparam int ROOT_W      = X_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int STEP_W      = $clog2(ROOT_W);
	localparam int FRAC_W      = 24;
	localparam int SCALE_W     = ROOT_W + DUTY_W;
	localparam int QUEUE_DEPTH = 2;

	// Configuration port geometry
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = ADDR_W - 2;

	localparam logic [INDEX_W-1:0] REG_OVR_EN    = 3'd0;
	localparam logic [INDEX_W-1:0] REG_OVR_ONE   = 3'd1;
	localparam logic [INDEX_W-1:0] REG_OVR_TWO   = 3'd2;
	localparam logic [INDEX_W-1:0] REG_OVR_THREE = 3'd3;
	localparam logic [INDEX_W-1:0] REG_OVR_FOUR  = 3'd4;

	// Mixer constants
	localparam logic [FIELD_W-1:0]        THRUST_MAX      = 24'd8388608;
	localparam logic signed [FIELD_W-1:0] TORQUE_LIM      = 24'sd2147484;
	localparam logic signed [29:0]        GAIN_THRUST     = 30'sd312500000;
	localparam logic signed [30:0]        GAIN_ROLL_PITCH = 31'sd600464308;
	localparam logic signed [32:0]        GAIN_YAW        = 33'sd3267973900;

	// Duty mapping constants
	localparam logic [OMEGA_W-1:0] OMEGA2_MIN = 24'd1690000;
	localparam logic [OMEGA_W-1:0] OMEGA2_MAX = 24'd12250000;
	localparam logic [ROOT_W-1:0]  OFFSET_B   = 25'd11146682;
	localparam logic [K_W-1:0]     GAIN_K     = 26'd54589088;
	localparam logic [X_W-1:0]     OFFSET_SQ  =
		{{(X_W-ROOT_W){1'b0}}, OFFSET_B} * {{(X_W-ROOT_W){1'b0}}, OFFSET_B};
	localparam logic [ROOT_W-1:0]  DUTY_MIN   = 25'd1677722;
	localparam logic [ROOT_W-1:0]  DUTY_MAX   = 25'd16777216;
	localparam logic [DUTY_W-1:0]  FULL_SCALE = 16'd65535;

	// Item classes decided at the front
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ZERO = 2'd0;
	localparam kind_t KIND_OVR  = 2'd1;
	localparam kind_t KIND_MIX  = 2'd2;

	typedef struct packed {
		logic                      armed;
		logic [FIELD_W-1:0]        thrust_cmd;
		logic signed [FIELD_W-1:0] roll_torque;
		logic signed [FIELD_W-1:0] pitch_torque;
		logic signed [FIELD_W-1:0] yaw_torque;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_one;
		logic [DUTY_W-1:0] duty_two;
		logic [DUTY_W-1:0] duty_three;
		logic [DUTY_W-1:0] duty_four;
	} duty_t;

	typedef struct packed {
		logic                                 ovr_en;
		logic [NUM_MOTORS-1:0][DUTY_W-1:0]    ovr_duty;
	} cfg_t;

	typedef struct packed {
		kind_t                                kind;
		logic [NUM_MOTORS-1:0][X_W-1:0]       rad;
	} qent_t;

endpackage

[rtl/qxmm_ifs.sv]
// Valid/ready channel interfaces for control items and duty results.
interface qxmm_cmd_if;
	logic             valid;
	logic             ready;
	qxmm_pkg::cmd_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qxmm_duty_if;
	logic             valid;
	logic             ready;
	qxmm_pkg::duty_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/qxmm_regs.sv]
// Override register bank behind the APB-style configuration port.
module qxmm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qxmm_pkg::ADDR_W-1:0]  paddr,
	input  logic [qxmm_pkg::DATA_W-1:0]  pwdata,
	output logic [qxmm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output qxmm_pkg::cfg_t               cfg
);
	import qxmm_pkg::*;

	logic [INDEX_W-1:0] index;
	logic               wr_en;
	cfg_t               cfg_q;

	assign index  = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (index)
				REG_OVR_EN:    cfg_q.ovr_en      <= pwdata[0];
				REG_OVR_ONE:   cfg_q.ovr_duty[0] <= pwdata[DUTY_W-1:0];
				REG_OVR_TWO:   cfg_q.ovr_duty[1] <= pwdata[DUTY_W-1:0];
				REG_OVR_THREE: cfg_q.ovr_duty[2] <= pwdata[DUTY_W-1:0];
				REG_OVR_FOUR:  cfg_q.ovr_duty[3] <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_OVR_EN:    prdata = DATA_W'(cfg_q.ovr_en);
			REG_OVR_ONE:   prdata = DATA_W'(cfg_q.ovr_duty[0]);
			REG_OVR_TWO:   prdata = DATA_W'(cfg_q.ovr_duty[1]);
			REG_OVR_THREE: prdata = DATA_W'(cfg_q.ovr_duty[2]);
			REG_OVR_FOUR:  prdata = DATA_W'(cfg_q.ovr_duty[3]);
			default:       prdata = '0;
		endcase
	end

endmodule

[rtl/qxmm_front.sv]
// Front pipeline: accept, classify, clamp, mix and form the square-root radicands.
module qxmm_front (
	input  logic              clk,
	input  logic              arst_n,
	qxmm_cmd_if.sink          cmd,
	input  logic              ovr_en,
	output logic              push,
	output qxmm_pkg::qent_t   push_data,
	input  logic              push_ready
);
	import qxmm_pkg::*;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	kind_t kind_s1, kind_s2, kind_s3, kind_s4;

	logic signed [SUM_W-1:0] tp_s1, xp_s1, yp_s1, zp_s1;
	logic signed [SUM_W-1:0] sum_s2 [NUM_MOTORS];
	logic [OMEGA_W-1:0]      w_s3 [NUM_MOTORS];
	logic [X_W-1:0]          x_s4 [NUM_MOTORS];

	logic [FIELD_W-1:0]        t_sat;
	logic signed [FIELD_W:0]   t_ext;
	logic signed [FIELD_W-1:0] r_sat, p_sat;
	kind_t                     kind_in;

	logic [SUM_W-1:0]          mag [NUM_MOTORS];
	logic [SUM_W-SHIFT_W-1:0]  w_raw [NUM_MOTORS];
	logic [OMEGA_W-1:0]        w_clamp [NUM_MOTORS];

	// Stall chain: a stage loads when it is empty or its content moves on
	assign rdy_s4    = !v_s4 || push_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd.ready = rdy_s1;

	assign push           = v_s4;
	always_comb begin
		push_data.kind = kind_s4;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			push_data.rad[i] = x_s4[i];
		end
	end

	// Classify the incoming item and clamp its thrust, roll and pitch
	always_comb begin
		if (ovr_en) begin
			kind_in = KIND_OVR;
		end else if (!cmd.data.armed) begin
			kind_in = KIND_ZERO;
		end else begin
			kind_in = KIND_MIX;
		end
		t_sat = (cmd.data.thrust_cmd > THRUST_MAX) ? THRUST_MAX : cmd.data.thrust_cmd;
		t_ext = {1'b0, t_sat};
		if (cmd.data.roll_torque > TORQUE_LIM) begin
			r_sat = TORQUE_LIM;
		end else if (cmd.data.roll_torque < -TORQUE_LIM) begin
			r_sat = -TORQUE_LIM;
		end else begin
			r_sat = cmd.data.roll_torque;
		end
		if (cmd.data.pitch_torque > TORQUE_LIM) begin
			p_sat = TORQUE_LIM;
		end else if (cmd.data.pitch_torque < -TORQUE_LIM) begin
			p_sat = -TORQUE_LIM;
		end else begin
			p_sat = cmd.data.pitch_torque;
		end
	end

	// Magnitude, drop the fraction and clamp omega squared
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			mag[i]     = sum_s2[i][SUM_W-1] ? SUM_W'(-sum_s2[i]) : SUM_W'(sum_s2[i]);
			w_raw[i]   = mag[i][SUM_W-1:SHIFT_W];
			if (w_raw[i] < (SUM_W-SHIFT_W)'(OMEGA2_MIN)) begin
				w_clamp[i] = OMEGA2_MIN;
			end else if (w_raw[i] > (SUM_W-SHIFT_W)'(OMEGA2_MAX)) begin
				w_clamp[i] = OMEGA2_MAX;
			end else begin
				w_clamp[i] = w_raw[i][OMEGA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cmd.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && cmd.valid) begin
			kind_s1 <= kind_in;
			tp_s1   <= t_ext * GAIN_THRUST;
			xp_s1   <= r_sat * GAIN_ROLL_PITCH;
			yp_s1   <= p_sat * GAIN_ROLL_PITCH;
			zp_s1   <= cmd.data.yaw_torque * GAIN_YAW;
		end
		if (rdy_s2 && v_s1) begin
			kind_s2   <= kind_s1;
			sum_s2[0] <= tp_s1 - xp_s1 - yp_s1 - zp_s1;
			sum_s2[1] <= tp_s1 - xp_s1 + yp_s1 + zp_s1;
			sum_s2[2] <= tp_s1 + xp_s1 + yp_s1 - zp_s1;
			sum_s2[3] <= tp_s1 + xp_s1 - yp_s1 + zp_s1;
		end
		if (rdy_s3 && v_s2) begin
			kind_s3 <= kind_s2;
			for (int i = 0; i < NUM_MOTORS; i++) begin
				w_s3[i] <= w_clamp[i];
			end
		end
		if (rdy_s4 && v_s3) begin
			kind_s4 <= kind_s3;
			for (int i = 0; i < NUM_MOTORS; i++) begin
				x_s4[i] <= OFFSET_SQ + X_W'(w_s3[i]) * X_W'(GAIN_K);
			end
		end
	end

endmodule

[rtl/qxmm_queue.sv]
// Short queue that decouples the mixer front from the square-root back end.
module qxmm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qxmm_pkg::qent_t   push_data,
	output logic              push_ready,
	output logic              pop_valid,
	output qxmm_pkg::qent_t   pop_data,
	input  logic              pop
);
	import qxmm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qent_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[rtl/qxmm_back.sv]
// Back end: four bit-serial square roots, duty scaling and the output register.
module qxmm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  qxmm_pkg::qent_t   pop_data,
	output logic              pop,
	input  qxmm_pkg::cfg_t    cfg,
	qxmm_duty_if.source       duty
);
	import qxmm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROOT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	kind_t              kind_q;
	logic [STEP_W-1:0]  step_q;
	logic [X_W-1:0]     rad_q  [NUM_MOTORS];
	logic [REM_W-1:0]   rem_q  [NUM_MOTORS];
	logic [ROOT_W-1:0]  root_q [NUM_MOTORS];
	logic               out_valid_q;
	duty_t              out_data_q;

	logic [REM_W-1:0]   rem_sh [NUM_MOTORS];
	logic [REM_W-1:0]   trial  [NUM_MOTORS];
	logic [REM_W-1:0]   rem_nx [NUM_MOTORS];
	logic [ROOT_W-1:0]  root_nx [NUM_MOTORS];
	logic [ROOT_W-1:0]  d_raw  [NUM_MOTORS];
	logic [ROOT_W-1:0]  d_sat  [NUM_MOTORS];
	logic [SCALE_W-1:0] scaled [NUM_MOTORS];
	logic [DUTY_W-1:0]  lane_duty [NUM_MOTORS];
	duty_t              res;
	logic               out_free;

	assign pop        = (state_q == ST_IDLE) && pop_valid;
	assign out_free   = !out_valid_q || duty.ready;
	assign duty.valid = out_valid_q;
	assign duty.data  = out_data_q;

	// One root bit per lane and cycle
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			rem_sh[i] = {rem_q[i][REM_W-3:0], rad_q[i][X_W-1:X_W-2]};
			trial[i]  = {root_q[i], 2'b01};
			if (rem_sh[i] >= trial[i]) begin
				rem_nx[i]  = rem_sh[i] - trial[i];
				root_nx[i] = {root_q[i][ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[i]  = rem_sh[i];
				root_nx[i] = {root_q[i][ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Subtract the offset, clamp to the duty range, scale to full scale and pick the duty by item class
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			d_raw[i] = root_q[i] - OFFSET_B;
			if (d_raw[i] < DUTY_MIN) begin
				d_sat[i] = DUTY_MIN;
			end else if (d_raw[i] > DUTY_MAX) begin
				d_sat[i] = DUTY_MAX;
			end else begin
				d_sat[i] = d_raw[i];
			end
			scaled[i] = SCALE_W'(d_sat[i]) * SCALE_W'(FULL_SCALE);
			unique case (kind_q)
				KIND_MIX: lane_duty[i] = scaled[i][FRAC_W +: DUTY_W];
				KIND_OVR: lane_duty[i] = cfg.ovr_duty[i];
				default:  lane_duty[i] = '0;
			endcase
		end
		res.duty_one   = lane_duty[0];
		res.duty_two   = lane_duty[1];
		res.duty_three = lane_duty[2];
		res.duty_four  = lane_duty[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (duty.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						step_q  <= '0;
						state_q <= (pop_data.kind == KIND_MIX) ? ST_ROOT : ST_DONE;
					end
				end
				ST_ROOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ROOT_W-1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= pop_data.kind;
			for (int i = 0; i < NUM_MOTORS; i++) begin
				rad_q[i]  <= pop_data.rad[i];
				rem_q[i]  <= '0;
				root_q[i] <= '0;
			end
		end else if (state_q == ST_ROOT) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				rad_q[i]  <= {rad_q[i][X_W-3:0], 2'b00};
				rem_q[i]  <= rem_nx[i];
				root_q[i] <= root_nx[i];
			end
		end
		if (state_q == ST_DONE && out_free) out_data_q <= res;
	end

endmodule

[rtl/quad_x_motor_mixer_sqrt.sv]
// Top level of the quad X motor mixer with square-root duty mapping.
//
// Usage: control items enter on the cmd channel (valid/ready, a transfer at
// a clock edge with both high). Each carries the arm flag, collective thrust
// and roll, pitch and yaw torques. Every item yields exactly one result on
// the duty channel: four 16-bit motor duties, full scale 65535.
// Override registers on the APB-style port replace all four duties when
// override_enable is set; a disarmed item gives zero duties.
//
// Mixed items pass through the square-root unit, which resolves one root bit
// per cycle in four parallel lanes (25 bits); the back end takes the next item
// from the queue only once the last result is in the output register.
// Disarmed and override items skip the square-root iteration.
//
// The four-stage front pipeline and a two-entry queue keep accepting items
// while the back end iterates, so cmd stays ready until they fill up.
// When the receiver stalls, the result holds in the output register, the
// back end finishes its current root and waits, and the queue and front
// fill before cmd drops ready. Reset clears all valid state and the
// override registers; no clearing pass is needed.
module quad_x_motor_mixer_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	qxmm_cmd_if.sink                     cmd,
	qxmm_duty_if.source                  duty,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qxmm_pkg::ADDR_W-1:0]  paddr,
	input  logic [qxmm_pkg::DATA_W-1:0]  pwdata,
	output logic [qxmm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import qxmm_pkg::*;

	cfg_t   cfg;
	logic   push, push_ready, pop_valid, pop;
	qent_t  push_data, pop_data;

	// Override registers
	qxmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Classify, clamp, mix and form the radicands
	qxmm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.ovr_en     (cfg.ovr_en),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// Hold items between the two halves so each can stall on its own
	qxmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	// Square roots, duty scaling and the output register
	qxmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.cfg       (cfg),
		.duty      (duty)
	);

endmodule
